// ===== rtl/ism_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and codes for the interval sort and merge core.
// ----------------------------------------------------------------------------
package ism_pkg;

   typedef logic signed [31:0] point_type;

   // One closed interval
   typedef struct packed {
      point_type start_point;
      point_type end_point;
   } span_type;

   // Contents of one cell as seen by its neighbors
   typedef struct packed {
      logic     valid;
      span_type span;
   } slot_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic     insert;  // place item in sorted order
      logic     shift;   // move every entry one cell toward the head
      logic     clear;   // drop all entries
      span_type item;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_ORDER = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // Sweep control from the top level to the merge unit
   typedef struct packed {
      logic       active;
      status_type status;
   } sweep_ctl_type;

   typedef enum logic {
      ST_LOAD,
      ST_SWEEP
   } state_type;

endpackage

// ===== rtl/ism_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism_cell
// One cell of the insertion-sorted chain: holds one interval and its valid.
// ----------------------------------------------------------------------------
module ism_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ism_pkg::cell_cmd_type cmd,
   input  ism_pkg::slot_type     left_slot,   // neighbor toward the head
   input  logic                  left_gt,
   input  ism_pkg::slot_type     right_slot,  // neighbor toward the tail
   output ism_pkg::slot_type     slot_out,
   output logic                  gt_out       // held start above new item start
);

   logic               valid_ff;
   logic               valid_in;
   ism_pkg::span_type  span_ff;
   ism_pkg::span_type  span_in;
   logic               gt;
   logic               take;

   assign gt   = valid_ff && (span_ff.start_point > cmd.item.start_point);
   // Sorted chain: cells above the new item open up, the first empty cell fills
   assign take = gt || (!valid_ff && left_slot.valid);

   always_comb begin
      valid_in = valid_ff;
      span_in  = span_ff;
      priority if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.shift) begin
         valid_in = right_slot.valid;
         span_in  = right_slot.span;
      end else if (cmd.insert && take) begin
         valid_in = 1'b1;
         span_in  = left_gt ? left_slot.span : cmd.item;
      end else begin
         valid_in = valid_ff;
         span_in  = span_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   assign slot_out.valid = valid_ff;
   assign slot_out.span  = span_ff;
   assign gt_out         = gt;

endmodule

// ===== rtl/ism_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ism_merge
// Merge unit: consumes the chain head in order, folds overlapping intervals
// and drives the result register.
// ----------------------------------------------------------------------------
module ism_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  ism_pkg::sweep_ctl_type sweep,
   input  ism_pkg::slot_type      head,
   output logic                   pop,
   output logic                   finish,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,  // merged_start [31:0], merged_end [63:32]
   output logic                   rsp_tlast,  // run_last
   output logic [1:0]             rsp_tuser   // status
);

   logic               have_cur_ff;
   logic               have_cur_in;
   ism_pkg::span_type  cur_ff;
   ism_pkg::span_type  cur_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   ism_pkg::span_type  out_span_ff;
   ism_pkg::span_type  out_span_in;
   logic               out_last_ff;
   logic               out_last_in;
   ism_pkg::status_type out_status_ff;
   ism_pkg::status_type out_status_in;
   logic               advance;
   logic               work;
   logic               bad;
   logic               gap;
   logic               emit;

   assign advance = !out_valid_ff || rsp_tready;
   assign work    = sweep.active && advance;
   assign bad     = (sweep.status == ism_pkg::STATUS_BAD_ORDER);
   assign finish  = work && (bad || !head.valid);
   assign pop     = work && !bad && head.valid;
   assign gap     = head.span.start_point > cur_ff.end_point;
   assign emit    = finish || (pop && have_cur_ff && gap);

   always_comb begin
      have_cur_in   = have_cur_ff;
      cur_in        = cur_ff;
      out_span_in   = out_span_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;

      if (emit) begin
         out_valid_in  = 1'b1;
         out_status_in = sweep.status;
         out_last_in   = finish;
         if (finish && (bad || !have_cur_ff)) begin
            out_span_in = '0;
         end else begin
            out_span_in = cur_ff;
         end
      end

      priority if (finish) begin
         have_cur_in = 1'b0;
      end else if (pop) begin
         have_cur_in = 1'b1;
         if (!have_cur_ff || gap) begin
            cur_in = head.span;
         end else if (head.span.end_point > cur_ff.end_point) begin
            cur_in.end_point = head.span.end_point;
         end
      end else begin
         have_cur_in = have_cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_cur_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         have_cur_ff  <= have_cur_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      out_span_ff   <= out_span_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_span_ff.end_point, out_span_ff.start_point};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ===== rtl/interval_sort_and_merge_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_sort_and_merge_core
// Loads a set of closed intervals, sorts them by start and emits the merged
// non-overlapping intervals in order.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one interval per beat, tdata = {end, start}, tlast marks
//   the final interval of a set. While loading, one beat is taken per cycle;
//   each beat is inserted in sorted order into a chain of MAX_INTERVALS cells.
//   rsp_ channel: one merged interval per beat, tlast on the last one of the
//   set, tuser carries the set status (ok, start above end, overflow).
//   A set with any interval whose start is above its end yields one beat of
//   zeros with status start-above-end; the set is dropped. Intervals arriving
//   with the chain full are dropped and all results carry status overflow.
// Timing:
//   After the last beat of a set the chain shifts toward the merge unit one
//   cell per cycle while rsp_tready does not stall it; the first result is
//   registered once the merge unit meets a gap or the end of the set, and in
//   the first sweep step for a set dropped for a reversed span.
//   req_tready is low during the sweep; the next set can start in the cycle
//   after the final result is registered.
//   A stall on rsp_tready freezes the sweep; a result register decouples the
//   two sides so nothing is lost or repeated.
// Reset: synchronous, clears all cell valids, the set status and the result
//   valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_sort_and_merge_core #(
   parameter int MAX_INTERVALS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // start_point [31:0], end_point [63:32]
   input  logic        req_tlast,   // set_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // merged_start [31:0], merged_end [63:32]
   output logic        rsp_tlast,   // run_last
   output logic [1:0]  rsp_tuser    // status
);

   ism_pkg::state_type     state_ff;
   ism_pkg::state_type     state_in;
   ism_pkg::status_type    status_ff;
   ism_pkg::status_type    status_in;
   ism_pkg::cell_cmd_type  cmd;
   ism_pkg::sweep_ctl_type sweep;
   ism_pkg::slot_type      slots [MAX_INTERVALS];
   logic [MAX_INTERVALS-1:0] gts;
   ism_pkg::span_type      item;
   logic                   accept;
   logic                   bad_item;
   logic                   full;
   logic                   pop;
   logic                   finish;

   assign item.start_point = req_tdata[31:0];
   assign item.end_point   = req_tdata[63:32];

   assign accept   = req_tvalid && req_tready;
   assign bad_item = item.start_point > item.end_point;
   // Chain is full when the tail cell holds an entry
   assign full     = slots[MAX_INTERVALS-1].valid;

   // Control: load until the last beat, then sweep until the merge unit
   // reports the set done.
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      req_tready = 1'b0;
      cmd.insert = 1'b0;
      cmd.shift  = pop;
      cmd.clear  = finish;
      cmd.item   = item;

      unique case (state_ff)
         ism_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (accept) begin
               priority if (bad_item) begin
                  status_in = ism_pkg::STATUS_BAD_ORDER;
               end else if (full) begin
                  if (status_ff != ism_pkg::STATUS_BAD_ORDER) begin
                     status_in = ism_pkg::STATUS_OVERFLOW;
                  end
               end else begin
                  if (status_ff != ism_pkg::STATUS_BAD_ORDER) begin
                     cmd.insert = 1'b1;
                  end
               end
               if (req_tlast) begin
                  state_in = ism_pkg::ST_SWEEP;
               end
            end
         end
         ism_pkg::ST_SWEEP: begin
            if (finish) begin
               state_in  = ism_pkg::ST_LOAD;
               status_in = ism_pkg::STATUS_OK;
            end
         end
         default: begin
            state_in = ism_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ism_pkg::ST_LOAD;
         status_ff <= ism_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   // Sorted chain, cell 0 holds the smallest start
   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
      ism_pkg::slot_type left_slot;
      ism_pkg::slot_type right_slot;
      logic              left_gt;

      if (i == 0) begin : g_head
         assign left_slot.valid = 1'b1;
         assign left_slot.span  = '0;
         assign left_gt         = 1'b0;
      end else begin : g_body
         assign left_slot = slots[i-1];
         assign left_gt   = gts[i-1];
      end

      if (i == MAX_INTERVALS - 1) begin : g_tail
         assign right_slot = '0;
      end else begin : g_next
         assign right_slot = slots[i+1];
      end

      ism_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_slot  (left_slot),
         .left_gt    (left_gt),
         .right_slot (right_slot),
         .slot_out   (slots[i]),
         .gt_out     (gts[i])
      );
   end

   assign sweep.active = (state_ff == ism_pkg::ST_SWEEP);
   assign sweep.status = status_ff;

   ism_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .sweep      (sweep),
      .head       (slots[0]),
      .pop        (pop),
      .finish     (finish),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
